[rtl/stit_pkg.sv]
// Shared types and constants for the session table with idle timeout.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package stit_pkg;

  // Fixed field widths
  localparam int KEY_W    = 50;
  localparam int OP_W     = 3;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 6;
  localparam int TMO_W    = 16;

  // Register map: one register, picked by the word-address bit
  localparam logic REG_IDLE_TIMEOUT = 1'b0;
  localparam logic [TMO_W-1:0] IDLE_TIMEOUT_RST = 16'd60;

  // Operation codes
  typedef enum logic [OP_W-1:0] {
    OP_TICK   = 3'd0,
    OP_CREATE = 3'd1,
    OP_EXISTS = 3'd2,
    OP_REMOVE = 3'd3,
    OP_SWEEP  = 3'd4
  } op_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_PRESENT   = 3'd1,
    STAT_NOT_FOUND = 3'd2,
    STAT_FULL      = 3'd3,
    STAT_DISABLED  = 3'd4
  } status_t;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESULT
  } state_t;

  // Enables into the slot store
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } stit_mem_ctl_t;

  // Actions decided by the sequencer in one cycle
  typedef struct packed {
    logic    emit;
    logic    emit_last;
    logic    emit_removed;
    logic    emit_present;
    status_t emit_status;
    logic    clr_slot;
    logic    set_slot;
    logic    advance;
  } stit_act_t;

endpackage

[rtl/stit_store.sv]
// Slot store: key and time stamp memories, one write port, one registered read port.
// Depends on stit_pkg for the key width and the enable struct.
`timescale 1ns / 1ps

module stit_store import stit_pkg::*; #(
  parameter int DEPTH   = 32,
  parameter int STAMP_W = 32
) (
  input  logic                     clk,
  input  stit_mem_ctl_t            ctl,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [KEY_W-1:0]         wr_key,
  input  logic [STAMP_W-1:0]       wr_stamp,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [KEY_W-1:0]         rd_key,
  output logic [STAMP_W-1:0]       rd_stamp
);

  logic [KEY_W-1:0]   key_mem   [DEPTH];
  logic [STAMP_W-1:0] stamp_mem [DEPTH];

  // Write a new session
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      key_mem[wr_addr]   <= wr_key;
      stamp_mem[wr_addr] <= wr_stamp;
    end
  end

  // Read one slot; hold the data while the scan stalls
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_key   <= key_mem[rd_addr];
      rd_stamp <= stamp_mem[rd_addr];
    end
  end

endmodule

[rtl/session_table_idle_timeout.sv]
// Session table with idle timeout: top level, sequencer and result register.
// Depends on stit_pkg and stit_store.
//
//   channel  handshake            payload
//   req      req_valid/req_ready  op, subscriber_key
//   rsp      rsp_valid/rsp_ready  status, removed_key, removed_valid, present,
//                                 session_count, last
//   cfg      APB write/read       idle_timeout at byte address 0
//
// Tick, unknown ops and a sweep with timeout zero go straight to the result state, with no scan.
// Create, exists, remove and sweep scan the slot memory one slot per cycle
// through its single read port; create, exists and remove stop early on a hit.
// Each removed key of a sweep is one extra result; the scan stalls in place
// while the result register is not taken. req_ready is high only when idle.
// Reset clears the valid bits, time and count and reloads the timeout with 60;
// no clearing pass.
`timescale 1ns / 1ps

module session_table_idle_timeout import stit_pkg::*; #(
  parameter int TABLE_SLOTS = 32,
  parameter int TIME_BITS   = 32
) (
  input  logic                clk,
  input  logic                rst,
  // request channel
  input  logic                req_valid,
  output logic                req_ready,
  input  logic [OP_W-1:0]     op,
  input  logic [KEY_W-1:0]    subscriber_key,
  // response channel
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output logic [STATUS_W-1:0] status,
  output logic [KEY_W-1:0]    removed_key,
  output logic                removed_valid,
  output logic                present,
  output logic [COUNT_W-1:0]  session_count,
  output logic                last,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int SLOT_W = $clog2(TABLE_SLOTS);
  localparam int CNT_W  = $clog2(TABLE_SLOTS + 1);

  state_t                 state, state_next;
  stit_act_t              act;
  stit_mem_ctl_t          mem_ctl;

  logic [TMO_W-1:0]       idle_timeout;
  logic [TIME_BITS-1:0]   cur_time;
  logic [COUNT_W-1:0]     live_count;
  logic [COUNT_W-1:0]     count_out;
  logic [TABLE_SLOTS-1:0] slot_valid;

  logic [OP_W-1:0]        op_q;
  logic [KEY_W-1:0]       key_q;
  status_t                res_status;

  logic [CNT_W-1:0]       idx;
  logic                   p_live;
  logic [SLOT_W-1:0]      p_slot;
  logic                   free_found;
  logic [SLOT_W-1:0]      free_slot;

  logic [KEY_W-1:0]       rd_key;
  logic [TIME_BITS-1:0]   rd_stamp;
  logic [TIME_BITS-1:0]   age;

  logic accept, out_free, scan_done, issue;
  logic slot_live, slot_match, slot_expired, is_sweep;
  logic want;

  assign accept    = req_valid && req_ready;
  assign req_ready = (state == S_IDLE);
  assign out_free  = !rsp_valid || rsp_ready;
  assign scan_done = (idx == CNT_W'(TABLE_SLOTS));
  assign issue     = !scan_done;
  assign is_sweep  = (op_q == OP_SWEEP);

  // Shared compare unit: key match and age check on the slot in the read register
  assign slot_live    = p_live && slot_valid[p_slot];
  assign age          = cur_time - rd_stamp;
  assign slot_match   = slot_live && !is_sweep && (rd_key == key_q);
  assign slot_expired = slot_live && is_sweep && (age > TIME_BITS'(idle_timeout));

  // Next state and per-cycle actions
  always_comb begin
    state_next      = state;
    act             = '0;
    act.emit_status = STAT_OK;
    want            = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          case (op) inside
            OP_CREATE, OP_EXISTS, OP_REMOVE: state_next = S_SCAN;
            OP_SWEEP: state_next = (idle_timeout == '0) ? S_RESULT : S_SCAN;
            default: state_next = S_RESULT;
          endcase
        end
      end
      S_SCAN: begin
        if (slot_match) begin
          want          = 1'b1;
          act.emit_last = 1'b1;
          case (op_q)
            OP_CREATE: act.emit_status = STAT_PRESENT;
            OP_EXISTS: act.emit_present = 1'b1;
            default: begin
              act.emit_removed = 1'b1;
              act.clr_slot     = out_free;
            end
          endcase
          if (out_free) begin
            state_next = S_IDLE;
          end
        end else if (slot_expired) begin
          want             = 1'b1;
          act.emit_removed = 1'b1;
          act.clr_slot     = out_free;
        end else if (!p_live && scan_done) begin
          want          = 1'b1;
          act.emit_last = 1'b1;
          case (op_q)
            OP_CREATE: begin
              act.emit_status = free_found ? STAT_OK : STAT_FULL;
              act.set_slot    = free_found && out_free;
            end
            OP_REMOVE: act.emit_status = STAT_NOT_FOUND;
            default: act.emit_status = STAT_OK;
          endcase
          if (out_free) begin
            state_next = S_IDLE;
          end
        end
        act.advance = !want || out_free;
      end
      S_RESULT: begin
        want            = 1'b1;
        act.emit_last   = 1'b1;
        act.emit_status = res_status;
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    act.emit = want && out_free;
  end

  // Count after this result
  always_comb begin
    count_out = live_count;
    if (act.clr_slot) begin
      count_out = live_count - COUNT_W'(1);
    end else if (act.set_slot) begin
      count_out = live_count + COUNT_W'(1);
    end
  end

  assign mem_ctl.rd_en = (state == S_SCAN) && act.advance && issue;
  assign mem_ctl.wr_en = act.set_slot;

  stit_store #(
    .DEPTH   (TABLE_SLOTS),
    .STAMP_W (TIME_BITS)
  ) u_store (
    .clk      (clk),
    .ctl      (mem_ctl),
    .wr_addr  (free_slot),
    .wr_key   (key_q),
    .wr_stamp (cur_time),
    .rd_addr  (idx[SLOT_W-1:0]),
    .rd_key   (rd_key),
    .rd_stamp (rd_stamp)
  );

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Table control state: time, count, valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_time   <= '0;
      live_count <= '0;
      slot_valid <= '0;
    end else begin
      if (accept && op == OP_TICK) begin
        cur_time <= cur_time + TIME_BITS'(1);
      end
      live_count <= count_out;
      if (act.clr_slot) begin
        slot_valid[p_slot] <= 1'b0;
      end
      if (act.set_slot) begin
        slot_valid[free_slot] <= 1'b1;
      end
    end
  end

  // Scan pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= '0;
      p_live     <= 1'b0;
      free_found <= 1'b0;
    end else if (accept) begin
      idx        <= '0;
      p_live     <= 1'b0;
      free_found <= 1'b0;
    end else if (state == S_SCAN && act.advance) begin
      if (p_live && !slot_valid[p_slot] && !free_found) begin
        free_found <= 1'b1;
      end
      p_live <= issue;
      if (issue) begin
        idx <= idx + CNT_W'(1);
      end
    end
  end

  // Scan pipeline payload
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q       <= op;
      key_q      <= subscriber_key;
      res_status <= (op == OP_SWEEP) ? STAT_DISABLED : STAT_OK;
    end
    if (state == S_SCAN && act.advance) begin
      if (p_live && !slot_valid[p_slot] && !free_found) begin
        free_slot <= p_slot;
      end
      if (issue) begin
        p_slot <= idx[SLOT_W-1:0];
      end
    end
  end

  // Result register: valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (act.emit) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  // Result register: payload
  always_ff @(posedge clk) begin
    if (act.emit) begin
      status        <= act.emit_status;
      removed_key   <= act.emit_removed ? rd_key : '0;
      removed_valid <= act.emit_removed;
      present       <= act.emit_present;
      session_count <= count_out;
      last          <= act.emit_last;
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      idle_timeout <= IDLE_TIMEOUT_RST;
    end else if (psel && penable && pwrite && paddr[2] == REG_IDLE_TIMEOUT) begin
      idle_timeout <= pwdata[TMO_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_IDLE_TIMEOUT) ? {16'd0, idle_timeout} : 32'd0;

endmodule

[rtl/stit_props.sv]
// Port-level properties of the session table, bound to the top level.
// Depends on stit_pkg for the status codes and field widths.
`timescale 1ns / 1ps

module stit_props import stit_pkg::*; #(
  parameter int TABLE_SLOTS = 32
) (
  input logic                clk,
  input logic                rst,
  input logic                req_valid,
  input logic                req_ready,
  input logic                rsp_valid,
  input logic                rsp_ready,
  input logic [STATUS_W-1:0] status,
  input logic [KEY_W-1:0]    removed_key,
  input logic                removed_valid,
  input logic                present,
  input logic [COUNT_W-1:0]  session_count,
  input logic                last
);

  // Block goes busy after taking an item
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("req_ready high right after an accepted item");

  // Live count never exceeds the table
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> session_count <= COUNT_W'(TABLE_SLOTS))
    else $error("session_count beyond table size");

  // Removed key only with ok status and zero when nothing removed
  a_removed_fields: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (removed_valid ? (status == STAT_OK) : (removed_key == '0)))
    else $error("inconsistent removed fields");

  // A positive lookup is a single closing ok result
  a_present_final: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && present |-> last && status == STAT_OK && !removed_valid)
    else $error("present set on a non-final or failed result");

  // Stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(removed_key)
      && $stable(session_count) && $stable(last))
    else $error("result changed while stalled");

endmodule

bind session_table_idle_timeout stit_props #(
  .TABLE_SLOTS (TABLE_SLOTS)
) u_stit_props (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req_valid),
  .req_ready     (req_ready),
  .rsp_valid     (rsp_valid),
  .rsp_ready     (rsp_ready),
  .status        (status),
  .removed_key   (removed_key),
  .removed_valid (removed_valid),
  .present       (present),
  .session_count (session_count),
  .last          (last)
);

[tb/sv/tb_session_table_idle_timeout.sv]
// Self-checking testbench for session_table_idle_timeout: drives session ops and
// idle_timeout writes, and checks every result against an in-bench table model.
// Depends on stit_pkg and the session_table_idle_timeout RTL.
`timescale 1ns / 1ps

module tb_session_table_idle_timeout;
  import stit_pkg::*;

  localparam int TABLE_SLOTS = 32;
  localparam int TIME_BITS   = 32;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 400;
  localparam int IDLE_PCT    = 24;

  localparam logic [2:0] ADDR_IDLE_TIMEOUT = {REG_IDLE_TIMEOUT, 2'b00};
  localparam logic [KEY_W-1:0] KEY_ALL_ONES = '1;
  localparam logic [KEY_W-1:0] KEY_TOP = 50'd999999999999999;
  localparam logic [63:0] KEY_SPAN = 64'd1000000000000000;

  // Op codes the block treats as no-ops
  localparam logic [OP_W-1:0] OP_RSVD5 = 3'd5;
  localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;

  typedef struct packed {
    logic [OP_W-1:0]  code;
    logic [KEY_W-1:0] key;
  } session_item_t;

  typedef struct packed {
    status_t            st;
    logic [KEY_W-1:0]   rkey;
    logic               rvalid;
    logic               hit;
    logic [COUNT_W-1:0] count;
    logic               fin;
  } table_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                req_valid = 1'b0;
  logic                req_ready;
  logic [OP_W-1:0]     op = '0;
  logic [KEY_W-1:0]    subscriber_key = '0;
  logic                rsp_valid;
  logic                rsp_ready = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [KEY_W-1:0]    removed_key;
  logic                removed_valid;
  logic                present;
  logic [COUNT_W-1:0]  session_count;
  logic                last;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [2:0]          paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  session_table_idle_timeout #(
    .TABLE_SLOTS(TABLE_SLOTS),
    .TIME_BITS  (TIME_BITS)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_ready     (req_ready),
    .op            (op),
    .subscriber_key(subscriber_key),
    .rsp_valid     (rsp_valid),
    .rsp_ready     (rsp_ready),
    .status        (status),
    .removed_key   (removed_key),
    .removed_valid (removed_valid),
    .present       (present),
    .session_count (session_count),
    .last          (last),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Mirror of the session table
  logic                   slot_live [TABLE_SLOTS] = '{default: 1'b0};
  logic [KEY_W-1:0]       slot_owner [TABLE_SLOTS];
  logic [TIME_BITS-1:0]   slot_since [TABLE_SLOTS];
  logic [TIME_BITS-1:0]   clock_now = '0;
  logic [COUNT_W-1:0]     live_sessions = '0;
  logic [TMO_W-1:0]       tmo_value = IDLE_TIMEOUT_RST;

  session_item_t    feed [$];
  table_result_t    results_due [$];
  logic [KEY_W-1:0] key_pool [$];
  session_item_t    next_item;
  table_result_t    got, want;

  int items_sent = 0;
  int items_taken = 0;
  int results_seen = 0;
  int removals_seen = 0;
  int full_refusals = 0;
  int errors = 0;
  int cycle_count;
  logic quiet = 1'b0;
  logic hold_go = 1'b0;
  logic rx_hold = 1'b0;

  // Queue one result; session_count reflects the table after this result
  function automatic void owe(status_t st, logic [KEY_W-1:0] k, logic rv, logic hit,
                              logic fin);
    table_result_t r;
    r = '{st: st, rkey: rv ? k : '0, rvalid: rv, hit: hit,
          count: live_sessions, fin: fin};
    results_due.insert(results_due.size(), r);
  endfunction

  // Apply one accepted item to the mirror and queue the results it causes
  function automatic void table_apply(logic [OP_W-1:0] code, logic [KEY_W-1:0] key);
    int hit_slot;
    int free_slot;
    logic [TIME_BITS-1:0] age;
    hit_slot = -1;
    free_slot = -1;
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      if (slot_live[i] && slot_owner[i] == key && hit_slot < 0) hit_slot = i;
      if (!slot_live[i] && free_slot < 0) free_slot = i;
    end
    case (code)
      OP_TICK: begin
        clock_now = clock_now + TIME_BITS'(1);
        owe(STAT_OK, '0, 1'b0, 1'b0, 1'b1);
      end
      OP_CREATE: begin
        if (hit_slot >= 0) begin
          owe(STAT_PRESENT, '0, 1'b0, 1'b0, 1'b1);
        end else if (free_slot < 0) begin
          owe(STAT_FULL, '0, 1'b0, 1'b0, 1'b1);
        end else begin
          slot_live[free_slot] = 1'b1;
          slot_owner[free_slot] = key;
          slot_since[free_slot] = clock_now;
          live_sessions = live_sessions + COUNT_W'(1);
          owe(STAT_OK, '0, 1'b0, 1'b0, 1'b1);
        end
      end
      OP_EXISTS: owe(STAT_OK, '0, 1'b0, hit_slot >= 0, 1'b1);
      OP_REMOVE: begin
        if (hit_slot < 0) begin
          owe(STAT_NOT_FOUND, '0, 1'b0, 1'b0, 1'b1);
        end else begin
          slot_live[hit_slot] = 1'b0;
          live_sessions = live_sessions - COUNT_W'(1);
          owe(STAT_OK, key, 1'b1, 1'b0, 1'b1);
        end
      end
      OP_SWEEP: begin
        if (tmo_value == '0) begin
          owe(STAT_DISABLED, '0, 1'b0, 1'b0, 1'b1);
        end else begin
          // Expire in ascending slot order, then close
          for (int i = 0; i < TABLE_SLOTS; i++) begin
            age = clock_now - slot_since[i];
            if (slot_live[i] && age > TIME_BITS'(tmo_value)) begin
              slot_live[i] = 1'b0;
              live_sessions = live_sessions - COUNT_W'(1);
              owe(STAT_OK, slot_owner[i], 1'b1, 1'b0, 1'b0);
            end
          end
          owe(STAT_OK, '0, 1'b0, 1'b0, 1'b1);
        end
      end
      default: owe(STAT_OK, '0, 1'b0, 1'b0, 1'b1);
    endcase
  endfunction

  // Request driver: hold the item until taken, then load the next or idle
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || items_taken == items_sent) begin
      if (feed.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
        next_item = feed.pop_front();
        op <= next_item.code;
        subscriber_key <= next_item.key;
        req_valid <= 1'b1;
        items_sent <= items_sent + 1;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Response ready: random stalls, plus the long hold-off
  always @(negedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= !rx_hold && (quiet || $urandom_range(99) >= IDLE_PCT);
    end
  end

  // Long receiver hold-off, counted here
  initial begin
    wait (hold_go);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // Monitor: predict on accepted items, check accepted results
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && req_ready) begin
        table_apply(op, subscriber_key);
        items_taken <= items_taken + 1;
      end
      if (rsp_valid && rsp_ready) begin
        got = '{st: status_t'(status), rkey: removed_key, rvalid: removed_valid,
                hit: present, count: session_count, fin: last};
        results_seen++;
        if (got.rvalid) removals_seen++;
        if (got.st == STAT_FULL) full_refusals++;
        if (results_due.size() == 0) begin
          errors++;
          $error("result with nothing outstanding: status %0d key %0h", status,
                 removed_key);
        end else begin
          want = results_due.pop_front();
          if (got.st !== want.st) begin
            errors++;
            $error("status: expected %0d, got %0d", want.st, got.st);
          end
          if (got.rkey !== want.rkey) begin
            errors++;
            $error("removed_key: expected %0h, got %0h", want.rkey, got.rkey);
          end
          if (got.rvalid !== want.rvalid) begin
            errors++;
            $error("removed_valid: expected %0b, got %0b", want.rvalid, got.rvalid);
          end
          if (got.hit !== want.hit) begin
            errors++;
            $error("present: expected %0b, got %0b", want.hit, got.hit);
          end
          if (got.count !== want.count) begin
            errors++;
            $error("session_count: expected %0d, got %0d", want.count, got.count);
          end
          if (got.fin !== want.fin) begin
            errors++;
            $error("last: expected %0b, got %0b", want.fin, got.fin);
          end
        end
      end
    end
  end

  // Cycle limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("run stopped at the cycle limit with %0d results outstanding",
             results_due.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic logic [KEY_W-1:0] raw_key();
    logic [63:0] r;
    r = {$urandom, $urandom};
    if ($urandom_range(3) == 0) return r[KEY_W-1:0];
    return KEY_W'(r % KEY_SPAN);
  endfunction

  // Add a key to the end of the pool of known keys
  function automatic void remember_key(logic [KEY_W-1:0] k);
    key_pool.insert(key_pool.size(), k);
  endfunction

  // Fresh key, remembered for later hits
  function automatic logic [KEY_W-1:0] mint_key();
    logic [KEY_W-1:0] k;
    k = raw_key();
    remember_key(k);
    if (key_pool.size() > 48) void'(key_pool.pop_front());
    return k;
  endfunction

  function automatic logic [KEY_W-1:0] pool_key();
    return key_pool[$urandom_range(key_pool.size() - 1)];
  endfunction

  task automatic queue_item(logic [OP_W-1:0] code, logic [KEY_W-1:0] key);
    session_item_t entry;
    entry = '{code: code, key: key};
    feed.insert(feed.size(), entry);
  endtask

  // Wait until every queued item is taken and every result has come
  task automatic drain();
    while (!(feed.size() == 0 && items_taken == items_sent && results_due.size() == 0))
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_xfer(input logic wr, input logic [31:0] wdata,
                          output logic [31:0] rdata);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= ADDR_IDLE_TIMEOUT;
    pwdata <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Write idle_timeout while idle, then read it back
  task automatic set_timeout(logic [TMO_W-1:0] value);
    logic [31:0] rd;
    drain();
    apb_xfer(1'b1, 32'(value), rd);
    tmo_value = value;
    apb_xfer(1'b0, '0, rd);
    if (rd[TMO_W-1:0] !== value) begin
      errors++;
      $error("idle_timeout: expected %0d, got %0d", value, rd[TMO_W-1:0]);
    end
    @(posedge clk);
  endtask

  // One weighted event of a session's life, with some noise
  task automatic add_session_event();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 30) begin
      queue_item(OP_CREATE, $urandom_range(1) ? pool_key() : mint_key());
    end else if (roll < 50) begin
      queue_item(OP_TICK, raw_key());
    end else if (roll < 62) begin
      queue_item(OP_EXISTS, $urandom_range(9) < 7 ? pool_key() : raw_key());
    end else if (roll < 74) begin
      queue_item(OP_REMOVE, $urandom_range(9) < 7 ? pool_key() : raw_key());
    end else if (roll < 86) begin
      queue_item(OP_SWEEP, raw_key());
    end else begin
      queue_item(OP_W'($urandom_range(7)), $urandom_range(1) ? pool_key() : raw_key());
    end
  endtask

  // Overfill the table, then tick twice and sweep; new sessions expire only if the timeout is under 2
  task automatic fill_and_flush();
    for (int i = 0; i < 36; i++) queue_item(OP_CREATE, mint_key());
    queue_item(OP_TICK, '0);
    queue_item(OP_TICK, '0);
    queue_item(OP_SWEEP, '0);
    queue_item(OP_EXISTS, pool_key());
    queue_item(OP_CREATE, mint_key());
  endtask

  logic [TMO_W-1:0] tmo_plan [12] = '{16'd3, 16'd65535, 16'd1, 16'd2, 16'd0, 16'd5,
                                      16'd1, 16'd60, 16'd4, 16'd2, 16'd1, 16'd7};

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: edge keys, every op, reserved ops, sweep cases
    remember_key('0);
    remember_key(KEY_ALL_ONES);
    remember_key(KEY_TOP);
    queue_item(OP_TICK, KEY_ALL_ONES);
    queue_item(OP_SWEEP, '0);
    queue_item(OP_CREATE, '0);
    queue_item(OP_CREATE, KEY_ALL_ONES);
    queue_item(OP_CREATE, KEY_TOP);
    queue_item(OP_CREATE, '0);
    queue_item(OP_EXISTS, '0);
    queue_item(OP_EXISTS, 50'h1234_5678);
    queue_item(OP_REMOVE, KEY_ALL_ONES);
    queue_item(OP_REMOVE, KEY_ALL_ONES);
    queue_item(OP_RSVD5, KEY_ALL_ONES);
    queue_item(OP_RSVD6, '0);
    queue_item(OP_RSVD7, KEY_TOP);
    queue_item(OP_TICK, '0);
    queue_item(OP_SWEEP, KEY_ALL_ONES);
    set_timeout('0);
    queue_item(OP_SWEEP, '0);
    set_timeout(16'd1);
    queue_item(OP_TICK, '0);
    queue_item(OP_TICK, '0);
    queue_item(OP_SWEEP, '0);
    queue_item(OP_EXISTS, '0);
    queue_item(OP_CREATE, KEY_ALL_ONES);

    // Random phases, one timeout each; pause for all results between them
    for (int p = 0; p < 12; p++) begin
      set_timeout(tmo_plan[p]);
      quiet = (p == 6);
      if (p == 2 || p == 10) begin
        if (p == 2) hold_go = 1'b1;
        fill_and_flush();
      end else begin
        for (int i = 0; i < 33; i++) add_session_event();
      end
    end

    drain();
    quiet = 1'b0;
    repeat (40) @(posedge clk);
    if (results_due.size() != 0) begin
      errors++;
      $error("%0d results never arrived", results_due.size());
    end
    $display("covered %0d items and %0d results: %0d sessions removed, %0d full-table refusals",
             items_taken, results_seen, removals_seen, full_refusals);
    $display("timeouts swept from 0 to 65535, including a %0d-cycle receiver hold-off",
             HOLD_CYCLES);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
